// File: hw/rtl/mrema_pkg.sv
// ----------------------------------------------------------------------------
// mrema_pkg
// shared types and constants of the multi-rate moving average tracker
// ----------------------------------------------------------------------------
`default_nettype none

package mrema_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;
  localparam int LANE_W    = 16;
  localparam int LANES     = 8;
  localparam int SMP_W     = 16;
  localparam int MEAN_W    = 32;
  localparam int MOM_W     = 48;
  localparam int VAL_W     = 49;
  localparam int MUL_A_W   = 24;
  localparam int QUO_W     = 32;
  localparam int DEN_W     = 16;
  localparam int DIVD_W    = 48;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 208;

  localparam logic [CFG_IDX_W-1:0] REG_DECAY_LO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_HI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_LO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_HI  = 3'd3;

  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_INTERP = 2'd1,
    MODE_READ   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    FLD_MX = 3'd0,
    FLD_MY = 3'd1,
    FLD_XX = 3'd2,
    FLD_XY = 3'd3,
    FLD_YY = 3'd4
  } fld_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_DIFF,
    ST_MLO,
    ST_MHI,
    ST_WB,
    ST_FIND,
    ST_RDA,
    ST_RDB,
    ST_DIVS,
    ST_DIV,
    ST_GRAB,
    ST_DONE
  } st_t;

  function automatic logic [VAL_W-1:0] ext_mean(input logic [MEAN_W-1:0] v);
    ext_mean = {{(VAL_W-MEAN_W){v[MEAN_W-1]}}, v};
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mrema_div.sv
// ----------------------------------------------------------------------------
// mrema_div
// restoring divider, one quotient bit per cycle, quotient below 2^32
// ----------------------------------------------------------------------------
`default_nettype none

module mrema_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [mrema_pkg::DIVD_W-1:0]      dividend,
  input  logic [mrema_pkg::DEN_W-1:0]       divisor,
  output logic                              done,
  output logic [mrema_pkg::QUO_W-1:0]       quotient
);

  localparam int CNT_W = $clog2(mrema_pkg::QUO_W + 1);

  logic                            busy_r;
  logic                            done_r;
  logic [CNT_W-1:0]                cnt_r;
  logic [mrema_pkg::DEN_W-1:0]     rem_r;
  logic [mrema_pkg::DEN_W-1:0]     den_r;
  logic [mrema_pkg::QUO_W-1:0]     quo_r;
  logic [mrema_pkg::DEN_W:0]       trial;
  logic [mrema_pkg::DEN_W:0]       trial_sub;
  logic                            ge;

  always_comb begin
    trial     = {rem_r, quo_r[mrema_pkg::QUO_W-1]};
    trial_sub = trial - {1'b0, den_r};
    ge        = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(mrema_pkg::QUO_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[mrema_pkg::DIVD_W-1:mrema_pkg::QUO_W];
      quo_r <= dividend[mrema_pkg::QUO_W-1:0];
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? trial_sub[mrema_pkg::DEN_W-1:0] : trial[mrema_pkg::DEN_W-1:0];
      quo_r <= {quo_r[mrema_pkg::QUO_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// File: hw/rtl/multi_rate_ema_moment_tracker.sv
// ----------------------------------------------------------------------------
// multi_rate_ema_moment_tracker
// bank of exponential moving averages of a 2d sample with second moments
// ----------------------------------------------------------------------------
// in channel: one request per item, tuser carries the mode (push sample,
// interpolate mean at an age, read one slot). out channel: one result for
// interpolate and read requests, none for push or the unused mode.
// cfg port: four 64-bit registers (decay factors, time marks); the user must write
// them only while the block is idle, the block itself does not enforce it.
// push: every one of the five values of each slot goes through the shared 24x17
// multiplier twice and a write-back step. interpolate runs two passes of the
// 32-step divider. read goes through the grab and done states.
// in_tready is high only while the sequencer is idle. a finished result sits
// in the output register; the next request is taken while it waits, and the
// sequencer holds its next result until the receiver takes the previous one.
// reset clears the configuration, all slots and the last sample at once.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_rate_ema_moment_tracker #(
  parameter int SLOTS       = 8,
  parameter int FACTOR_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [55:0]  in_tdata,   // sample_x, sample_y, query_age, slot_index
  input  logic [1:0]   in_tuser,   // mode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [207:0] out_tdata,  // mean_x, mean_y, moment_xx, moment_xy, moment_yy
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_wdata
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int GW     = FACTOR_BITS + 1;
  localparam int BW     = (GW > 16) ? GW : 16;
  localparam int PW     = mrema_pkg::MUL_A_W + BW;
  localparam int SUM_W  = PW + mrema_pkg::MUL_A_W + 1;
  localparam int SH_L   = (FACTOR_BITS >= 16) ? FACTOR_BITS - 16 : 0;
  localparam int SH_R   = (FACTOR_BITS < 16) ? 16 - FACTOR_BITS : 0;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
  localparam int VW = mrema_pkg::VAL_W;

  mrema_pkg::st_t   state_r, state_nxt;
  mrema_pkg::fld_t  fld_r;
  mrema_pkg::mode_t mode_in;

  logic signed [15:0] smp_x, smp_y;
  logic [15:0]        age_in;
  logic [2:0]         sidx_in;

  logic [63:0] dec_lo_r, dec_hi_r, mark_lo_r, mark_hi_r;
  logic [15:0] dec_lane  [mrema_pkg::LANES];
  logic [15:0] mark_lane [mrema_pkg::LANES];

  logic [31:0] mx_r [SLOTS];
  logic [31:0] my_r [SLOTS];
  logic [47:0] xx_r [SLOTS];
  logic [47:0] xy_r [SLOTS];
  logic [47:0] yy_r [SLOTS];
  logic [15:0] last_x_r, last_y_r;

  logic [SLOT_W-1:0] slot_r, hi_r;
  logic [2:0]        slot3;
  logic [31:0]       rmx, rmy;
  logic [47:0]       rxx, rxy, ryy;

  logic [15:0] age_r, num_r, den_r;
  logic        lerp_r, comp_r, zmom_r;
  logic [47:0] txx_r, txy_r, tyy_r;
  logic [31:0] a_x_r, a_y_r, b_x_r, b_y_r;
  logic [31:0] res_x_r, res_y_r;
  logic [47:0] res_xx_r, res_xy_r, res_yy_r;
  logic        out_valid_r;
  logic [207:0] out_data_r;

  logic [VW-1:0] m_r;
  logic          neg_r;
  logic [47:0]   u_r;
  logic [BW-1:0] b_r;
  logic [PW-1:0] plo_r, phi_r;

  logic [VW-1:0] m_sel, t_sel, diff, wb_val, div_val;
  logic [47:0]   u_nxt, mag;
  logic [GW-1:0] g;
  logic [39:0]   raw_w, f_w;
  logic [SUM_W-1:0] sum_base, sum_blend, sum_lerp;

  logic [mrema_pkg::MUL_A_W-1:0] mul_a;
  logic [BW-1:0]                 mul_b;
  logic [PW-1:0]                 mul_p;
  logic [16:0] ax, ay, op_a, op_b;
  logic        sq_neg;
  logic [47:0] sq_t;

  logic [2:0]  hit3, lo3;
  logic        below, beyond;

  logic        out_load, div_start, div_done;
  logic [31:0] div_q;

  // input unpacking
  always_comb begin
    mode_in = mrema_pkg::mode_t'(in_tuser);
    smp_x   = in_tdata[15:0];
    smp_y   = in_tdata[31:16];
    age_in  = in_tdata[47:32];
    sidx_in = in_tdata[50:48];
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_lo_r  <= '0;
      dec_hi_r  <= '0;
      mark_lo_r <= '0;
      mark_hi_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mrema_pkg::REG_DECAY_LO: dec_lo_r  <= cfg_wdata;
        mrema_pkg::REG_DECAY_HI: dec_hi_r  <= cfg_wdata;
        mrema_pkg::REG_MARK_LO:  mark_lo_r <= cfg_wdata;
        mrema_pkg::REG_MARK_HI:  mark_hi_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dec_lane[i]    = dec_lo_r[16*i +: 16];
      dec_lane[i+4]  = dec_hi_r[16*i +: 16];
      mark_lane[i]   = mark_lo_r[16*i +: 16];
      mark_lane[i+4] = mark_hi_r[16*i +: 16];
    end
  end

  // slot read at the single pointer
  always_comb begin
    slot3 = 3'(slot_r);
    rmx   = mx_r[slot_r];
    rmy   = my_r[slot_r];
    rxx   = xx_r[slot_r];
    rxy   = xy_r[slot_r];
    ryy   = yy_r[slot_r];
  end

  // sample weight of the current slot
  always_comb begin
    raw_w = 40'(dec_lane[slot3]);
    f_w   = (FACTOR_BITS >= 16) ? (raw_w << SH_L) : (raw_w >> SH_R);
    g     = (GW'(1) << FACTOR_BITS) - f_w[GW-1:0];
  end

  // bracket search over the time marks
  always_comb begin
    hit3 = 3'(SLOTS - 1);
    for (int i = SLOTS - 2; i >= 1; i--) begin
      if (age_r < mark_lane[i]) hit3 = 3'(i);
    end
    lo3    = hit3 - 3'd1;
    below  = age_r < mark_lane[0];
    beyond = age_r >= mark_lane[SLOTS-1];
  end

  // operand select and difference
  always_comb begin
    m_sel = '0;
    t_sel = '0;
    if (lerp_r) begin
      m_sel = mrema_pkg::ext_mean(comp_r ? a_y_r : a_x_r);
      t_sel = mrema_pkg::ext_mean(comp_r ? b_y_r : b_x_r);
    end else begin
      case (fld_r)
        mrema_pkg::FLD_MX: begin
          m_sel = mrema_pkg::ext_mean(rmx);
          t_sel = mrema_pkg::ext_mean({last_x_r, 16'h0});
        end
        mrema_pkg::FLD_MY: begin
          m_sel = mrema_pkg::ext_mean(rmy);
          t_sel = mrema_pkg::ext_mean({last_y_r, 16'h0});
        end
        mrema_pkg::FLD_XX: begin
          m_sel = {1'b0, rxx};
          t_sel = {txx_r[47], txx_r};
        end
        mrema_pkg::FLD_XY: begin
          m_sel = {rxy[47], rxy};
          t_sel = {txy_r[47], txy_r};
        end
        mrema_pkg::FLD_YY: begin
          m_sel = {1'b0, ryy};
          t_sel = {tyy_r[47], tyy_r};
        end
        default: ;
      endcase
    end
    diff  = t_sel - m_sel;
    u_nxt = diff[VW-1] ? 48'(VW'(0) - diff) : diff[47:0];
  end

  // product sums, rounding and write-back values
  always_comb begin
    sum_base  = SUM_W'(plo_r) + (SUM_W'(phi_r) << mrema_pkg::MUL_A_W);
    sum_blend = sum_base + (SUM_W'(1) << (FACTOR_BITS - 1));
    sum_lerp  = sum_base + SUM_W'(den_r >> 1);
    mag       = 48'(sum_blend >> FACTOR_BITS);
    wb_val    = neg_r ? (m_r - {1'b0, mag}) : (m_r + {1'b0, mag});
    div_val   = neg_r ? (m_r - VW'(div_q)) : (m_r + VW'(div_q));
  end

  // squares of the new sample
  always_comb begin
    ax     = last_x_r[15] ? (17'(0) - {1'b1, last_x_r}) : {1'b0, last_x_r};
    ay     = last_y_r[15] ? (17'(0) - {1'b1, last_y_r}) : {1'b0, last_y_r};
    op_a   = (fld_r == mrema_pkg::FLD_YY) ? ay : ax;
    op_b   = (fld_r == mrema_pkg::FLD_XX) ? ax : ay;
    sq_neg = (fld_r == mrema_pkg::FLD_XY) && (last_x_r[15] ^ last_y_r[15]);
    sq_t   = {1'b0, mul_p[30:0], 16'h0};
    if (sq_neg) sq_t = 48'(0) - sq_t;
  end

  // shared multiplier
  assign mul_p = {{BW{1'b0}}, mul_a} * {{mrema_pkg::MUL_A_W{1'b0}}, mul_b};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mrema_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          unique case (mode_in)
            mrema_pkg::MODE_PUSH:   state_nxt = mrema_pkg::ST_SQ;
            mrema_pkg::MODE_INTERP: state_nxt = mrema_pkg::ST_FIND;
            mrema_pkg::MODE_READ:   state_nxt = mrema_pkg::ST_GRAB;
            default:                state_nxt = mrema_pkg::ST_IDLE;
          endcase
        end
      end
      mrema_pkg::ST_SQ: begin
        if (fld_r == mrema_pkg::FLD_YY) state_nxt = mrema_pkg::ST_DIFF;
      end
      mrema_pkg::ST_DIFF: state_nxt = mrema_pkg::ST_MLO;
      mrema_pkg::ST_MLO:  state_nxt = mrema_pkg::ST_MHI;
      mrema_pkg::ST_MHI:  state_nxt = lerp_r ? mrema_pkg::ST_DIVS : mrema_pkg::ST_WB;
      mrema_pkg::ST_WB: begin
        if (fld_r == mrema_pkg::FLD_YY && slot_r == LAST_SLOT) state_nxt = mrema_pkg::ST_IDLE;
        else state_nxt = mrema_pkg::ST_DIFF;
      end
      mrema_pkg::ST_FIND: begin
        if (below) state_nxt = mrema_pkg::ST_RDB;
        else if (beyond) state_nxt = mrema_pkg::ST_GRAB;
        else state_nxt = mrema_pkg::ST_RDA;
      end
      mrema_pkg::ST_RDA:  state_nxt = mrema_pkg::ST_RDB;
      mrema_pkg::ST_RDB:  state_nxt = mrema_pkg::ST_DIFF;
      mrema_pkg::ST_DIVS: state_nxt = mrema_pkg::ST_DIV;
      mrema_pkg::ST_DIV: begin
        if (div_done) state_nxt = comp_r ? mrema_pkg::ST_DONE : mrema_pkg::ST_DIFF;
      end
      mrema_pkg::ST_GRAB: state_nxt = mrema_pkg::ST_DONE;
      mrema_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) state_nxt = mrema_pkg::ST_IDLE;
      end
      default: state_nxt = mrema_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = state_r == mrema_pkg::ST_IDLE;
    out_load  = (state_r == mrema_pkg::ST_DONE) && (!out_valid_r || out_tready);
    div_start = state_r == mrema_pkg::ST_DIVS;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      mrema_pkg::ST_SQ: begin
        mul_a = mrema_pkg::MUL_A_W'(op_a);
        mul_b = BW'(op_b);
      end
      mrema_pkg::ST_MLO: begin
        mul_a = u_r[23:0];
        mul_b = b_r;
      end
      mrema_pkg::ST_MHI: begin
        mul_a = u_r[47:24];
        mul_b = b_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= mrema_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  // control registers and slot state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fld_r    <= mrema_pkg::FLD_MX;
      slot_r   <= '0;
      lerp_r   <= 1'b0;
      comp_r   <= 1'b0;
      last_x_r <= '0;
      last_y_r <= '0;
      for (int s = 0; s < SLOTS; s++) begin
        mx_r[s] <= '0;
        my_r[s] <= '0;
        xx_r[s] <= '0;
        xy_r[s] <= '0;
        yy_r[s] <= '0;
      end
    end else begin
      unique case (state_r)
        mrema_pkg::ST_IDLE: begin
          if (in_tvalid) begin
            lerp_r <= mode_in != mrema_pkg::MODE_PUSH;
            fld_r  <= mrema_pkg::FLD_XX;
            if (mode_in == mrema_pkg::MODE_PUSH) begin
              last_x_r <= smp_x;
              last_y_r <= smp_y;
            end
            if (mode_in == mrema_pkg::MODE_READ) begin
              slot_r <= (4'(sidx_in) >= 4'(SLOTS)) ? LAST_SLOT : SLOT_W'(sidx_in);
            end
          end
        end
        mrema_pkg::ST_SQ: begin
          if (fld_r == mrema_pkg::FLD_YY) begin
            fld_r  <= mrema_pkg::FLD_MX;
            slot_r <= '0;
          end else begin
            fld_r <= mrema_pkg::fld_t'(fld_r + 3'd1);
          end
        end
        mrema_pkg::ST_WB: begin
          case (fld_r)
            mrema_pkg::FLD_MX: mx_r[slot_r] <= wb_val[31:0];
            mrema_pkg::FLD_MY: my_r[slot_r] <= wb_val[31:0];
            mrema_pkg::FLD_XX: xx_r[slot_r] <= wb_val[47:0];
            mrema_pkg::FLD_XY: xy_r[slot_r] <= wb_val[47:0];
            default:           yy_r[slot_r] <= wb_val[47:0];
          endcase
          if (fld_r == mrema_pkg::FLD_YY) begin
            fld_r <= mrema_pkg::FLD_MX;
            if (slot_r != LAST_SLOT) slot_r <= slot_r + SLOT_W'(1);
          end else begin
            fld_r <= mrema_pkg::fld_t'(fld_r + 3'd1);
          end
        end
        mrema_pkg::ST_FIND: begin
          if (below) slot_r <= '0;
          else if (beyond) slot_r <= LAST_SLOT;
          else slot_r <= SLOT_W'(lo3);
        end
        mrema_pkg::ST_RDA: slot_r <= hi_r;
        mrema_pkg::ST_RDB: comp_r <= 1'b0;
        mrema_pkg::ST_DIV: begin
          if (div_done) comp_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      mrema_pkg::ST_IDLE: begin
        age_r  <= age_in;
        zmom_r <= 1'b0;
      end
      mrema_pkg::ST_SQ: begin
        case (fld_r)
          mrema_pkg::FLD_XX: txx_r <= sq_t;
          mrema_pkg::FLD_XY: txy_r <= sq_t;
          default:           tyy_r <= sq_t;
        endcase
      end
      mrema_pkg::ST_DIFF: begin
        m_r   <= m_sel;
        neg_r <= diff[VW-1];
        u_r   <= u_nxt;
        b_r   <= lerp_r ? BW'(num_r) : BW'(g);
      end
      mrema_pkg::ST_MLO: plo_r <= mul_p;
      mrema_pkg::ST_MHI: phi_r <= mul_p;
      mrema_pkg::ST_FIND: begin
        zmom_r   <= beyond && !below;
        res_xx_r <= '0;
        res_xy_r <= '0;
        res_yy_r <= '0;
        hi_r     <= SLOT_W'(hit3);
        if (below) begin
          a_x_r <= {last_x_r, 16'h0};
          a_y_r <= {last_y_r, 16'h0};
          num_r <= age_r;
          den_r <= mark_lane[0];
        end else begin
          num_r <= age_r - mark_lane[lo3];
          den_r <= mark_lane[hit3] - mark_lane[lo3];
        end
      end
      mrema_pkg::ST_RDA: begin
        a_x_r <= rmx;
        a_y_r <= rmy;
      end
      mrema_pkg::ST_RDB: begin
        b_x_r <= rmx;
        b_y_r <= rmy;
      end
      mrema_pkg::ST_DIV: begin
        if (div_done) begin
          if (comp_r) res_y_r <= div_val[31:0];
          else res_x_r <= div_val[31:0];
        end
      end
      mrema_pkg::ST_GRAB: begin
        res_x_r  <= rmx;
        res_y_r  <= rmy;
        res_xx_r <= (lerp_r && zmom_r) ? '0 : rxx;
        res_xy_r <= (lerp_r && zmom_r) ? '0 : rxy;
        res_yy_r <= (lerp_r && zmom_r) ? '0 : ryy;
      end
      default: ;
    endcase
  end

  mrema_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_lerp[mrema_pkg::DIVD_W-1:0]),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_load) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data_r <= {res_yy_r, res_xy_r, res_xx_r, res_y_r, res_x_r};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= LAST_SLOT)
    else $error("slot pointer out of range");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == mrema_pkg::ST_DIV)
    else $error("divider finished outside its wait state");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == mrema_pkg::ST_DONE))
    else $error("result shown without a finished request");

endmodule

`default_nettype wire

// File: test/multi_rate_ema_moment_tracker_chk.sv
// ----------------------------------------------------------------------------
// multi_rate_ema_moment_tracker_chk
// watches the cfg, in and out ports, predicts each result and compares it
// ----------------------------------------------------------------------------
`default_nettype none

module multi_rate_ema_moment_tracker_chk (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [55:0]  in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [207:0] out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_wdata,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [47:0] yy;
    logic [47:0] xy;
    logic [47:0] xx;
    logic [31:0] my;
    logic [31:0] mx;
  } moments_t;

  logic [63:0] decay_lo, decay_hi, mark_lo, mark_hi;
  longint      mean_x [8];
  longint      mean_y [8];
  longint      mom_xx [8];
  longint      mom_xy [8];
  longint      mom_yy [8];
  longint      last_x, last_y;
  moments_t    expected_q [$];

  function automatic longint unsigned lane(logic [63:0] lo, logic [63:0] hi, int s);
    logic [63:0] r;
    r = (s < 4) ? lo : hi;
    return longint'(r[16*(s%4) +: 16]);
  endfunction

  function automatic longint blend_toward(longint m, longint t, longint unsigned g);
    bit neg;
    longint unsigned u, mag;
    neg = t < m;
    u = neg ? m - t : t - m;
    mag = (((u >> 24) * g) << 8) + (((u & 64'hFFFFFF) * g + 64'd32768) >> 16);
    return neg ? m - longint'(mag) : m + longint'(mag);
  endfunction

  function automatic longint lerp_between(longint a, longint b, longint unsigned num,
                                          longint unsigned den);
    bit neg;
    longint unsigned u, mag;
    neg = b < a;
    u = neg ? a - b : b - a;
    mag = (u * num + den / 2) / den;
    return neg ? a - longint'(mag) : a + longint'(mag);
  endfunction

  task automatic push_sample(logic [15:0] xs, logic [15:0] ys);
    longint x, y, g;
    x = longint'($signed(xs));
    y = longint'($signed(ys));
    last_x = x;
    last_y = y;
    for (int s = 0; s < 8; s++) begin
      g = 65536 - lane(decay_lo, decay_hi, s);
      mean_x[s] = blend_toward(mean_x[s], x * 65536, g);
      mean_y[s] = blend_toward(mean_y[s], y * 65536, g);
      mom_xx[s] = blend_toward(mom_xx[s], x * x * 65536, g);
      mom_xy[s] = blend_toward(mom_xy[s], x * y * 65536, g);
      mom_yy[s] = blend_toward(mom_yy[s], y * y * 65536, g);
    end
  endtask

  function automatic moments_t mean_at_age(longint unsigned age);
    moments_t r;
    longint unsigned t0, tl, ta, tb;
    longint mx, my;
    int s;
    t0 = lane(mark_lo, mark_hi, 0);
    tl = lane(mark_lo, mark_hi, 7);
    if (age < t0) begin
      mx = lerp_between(last_x * 65536, mean_x[0], age, t0);
      my = lerp_between(last_y * 65536, mean_y[0], age, t0);
    end else if (age >= tl) begin
      mx = mean_x[7];
      my = mean_y[7];
    end else begin
      for (s = 1; s < 7; s++)
        if (age < lane(mark_lo, mark_hi, s)) break;
      ta = lane(mark_lo, mark_hi, s - 1);
      tb = lane(mark_lo, mark_hi, s);
      mx = lerp_between(mean_x[s-1], mean_x[s], age - ta, tb - ta);
      my = lerp_between(mean_y[s-1], mean_y[s], age - ta, tb - ta);
    end
    r = '0;
    r.mx = mx[31:0];
    r.my = my[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    moments_t got, want, rd;
    int s;
    if (!rst_n) begin
      decay_lo <= '0; decay_hi <= '0; mark_lo <= '0; mark_hi <= '0;
      for (int i = 0; i < 8; i++) begin
        mean_x[i] = 0; mean_y[i] = 0; mom_xx[i] = 0; mom_xy[i] = 0; mom_yy[i] = 0;
      end
      last_x = 0;
      last_y = 0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mrema_pkg::REG_DECAY_LO: decay_lo <= cfg_wdata;
          mrema_pkg::REG_DECAY_HI: decay_hi <= cfg_wdata;
          mrema_pkg::REG_MARK_LO:  mark_lo  <= cfg_wdata;
          mrema_pkg::REG_MARK_HI:  mark_hi  <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %h", out_tdata);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: mx %h/%h my %h/%h xx %h/%h xy %h/%h yy %h/%h (exp/act)",
                       want.mx, got.mx, want.my, got.my, want.xx, got.xx,
                       want.xy, got.xy, want.yy, got.yy);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        case (mrema_pkg::mode_t'(in_tuser))
          mrema_pkg::MODE_PUSH: push_sample(in_tdata[15:0], in_tdata[31:16]);
          mrema_pkg::MODE_INTERP:
            expected_q.push_back(mean_at_age(longint'(in_tdata[47:32])));
          mrema_pkg::MODE_READ: begin
            s = in_tdata[50:48];
            rd.mx = mean_x[s][31:0];
            rd.my = mean_y[s][31:0];
            rd.xx = mom_xx[s][47:0];
            rd.xy = mom_xy[s][47:0];
            rd.yy = mom_yy[s][47:0];
            expected_q.push_back(rd);
          end
          default: ;
        endcase
      end
    end
    pending <= expected_q.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
  end

endmodule

`default_nettype wire

// File: test/multi_rate_ema_moment_tracker_tb.sv
// ----------------------------------------------------------------------------
// multi_rate_ema_moment_tracker_tb
// drives pushes, interpolations and slot reads through several register
// settings with random idling on both sides; the checker predicts and compares
// ----------------------------------------------------------------------------
`default_nettype none

module multi_rate_ema_moment_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [2:0] REG_UNUSED = 3'd5;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [55:0]  in_tdata = '0;
  logic [1:0]   in_tuser = mrema_pkg::MODE_PUSH;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [207:0] out_tdata;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = mrema_pkg::REG_DECAY_LO;
  logic [63:0]  cfg_wdata = '0;
  int           fail_count, pending;
  bit           calm = 1'b0;
  bit           long_hold = 1'b0;
  int           hold_left = 0;
  int           stall_left = 0;
  int           cycles = 0;
  int           sent [4];
  logic [63:0]  marks_lo, marks_hi;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  multi_rate_ema_moment_tracker uut (.*);

  multi_rate_ema_moment_tracker_chk chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off
  always @(posedge clk) begin
    if (long_hold && hold_left == 0) begin
      hold_left <= 1500;
      long_hold <= 1'b0;
      out_tready <= 1'b0;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_left == 1) begin
      hold_left <= 0;
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 19) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send(mrema_pkg::mode_t m, logic [15:0] x, logic [15:0] y,
                      logic [15:0] age, logic [2:0] slot);
    int gap;
    gap = (!calm && $urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= {5'b0, slot, age, y, x};
    do @(posedge clk); while (!in_tready);
    sent[m]++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // kind 0 ascending random, 1 all zero, 2 all max, 3 unordered random
  task automatic program_regs(logic [63:0] dlo, logic [63:0] dhi, int kind);
    int t;
    t = $urandom_range(0, 3000);
    for (int s = 0; s < 8; s++) begin
      case (kind)
        0: t = (t + $urandom_range(1, 2000) > 65535) ? 65535 : t + $urandom_range(1, 2000);
        1: t = 0;
        2: t = 65535;
        default: t = $urandom_range(0, 65535);
      endcase
      if (s < 4) marks_lo[16*s +: 16] = t[15:0];
      else marks_hi[16*(s-4) +: 16] = t[15:0];
    end
    write_reg(mrema_pkg::REG_DECAY_LO, dlo);
    write_reg(mrema_pkg::REG_DECAY_HI, dhi);
    write_reg(mrema_pkg::REG_MARK_LO, marks_lo);
    write_reg(mrema_pkg::REG_MARK_HI, marks_hi);
    write_reg(REG_UNUSED, rand64());
  endtask

  task automatic random_item();
    int r;
    logic [15:0] x, y, age;
    r = $urandom_range(0, 99);
    x = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 16'h7FFF : 16'h8000)
                                    : 16'($urandom());
    y = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 16'h7FFF : 16'h8000)
                                    : 16'($urandom());
    case ($urandom_range(0, 3))
      0: age = 16'($urandom());
      1: age = marks_lo[16*$urandom_range(0, 3) +: 16] + 16'($urandom_range(0, 2) - 1);
      default: age = marks_hi[16*$urandom_range(0, 3) +: 16] - 16'($urandom_range(0, 50));
    endcase
    if (r < 58) send(mrema_pkg::MODE_PUSH, x, y, age, 3'($urandom()));
    else if (r < 78) send(mrema_pkg::MODE_INTERP, x, y, age, 3'($urandom()));
    else if (r < 97) send(mrema_pkg::MODE_READ, x, y, age, 3'($urandom()));
    else send(mrema_pkg::MODE_NONE, x, y, age, 3'($urandom()));
  endtask

  initial begin
    foreach (sent[i]) sent[i] = 0;
    marks_lo = '0;
    marks_hi = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: half and extreme factors, ascending marks
    program_regs(64'h0000_FFFF_8000_C000, 64'hFFF0_F000_E000_0001, 0);
    send(mrema_pkg::MODE_PUSH, 16'h7FFF, 16'h8000, 16'h0, 3'd0);
    send(mrema_pkg::MODE_PUSH, 16'h8000, 16'h7FFF, 16'h0, 3'd0);
    send(mrema_pkg::MODE_PUSH, 16'h0000, 16'h0000, 16'h0, 3'd0);
    send(mrema_pkg::MODE_PUSH, 16'hFFFF, 16'h0001, 16'h0, 3'd0);
    for (int s = 0; s < 8; s++) send(mrema_pkg::MODE_READ, 16'h0, 16'h0, 16'h0, 3'(s));
    send(mrema_pkg::MODE_INTERP, 16'h0, 16'h0, 16'h0, 3'd0);
    send(mrema_pkg::MODE_INTERP, 16'h0, 16'h0, marks_lo[15:0] - 16'd1, 3'd0);
    send(mrema_pkg::MODE_INTERP, 16'h0, 16'h0, marks_lo[15:0], 3'd0);
    send(mrema_pkg::MODE_INTERP, 16'h0, 16'h0, marks_lo[47:32] + 16'd1, 3'd0);
    send(mrema_pkg::MODE_INTERP, 16'h0, 16'h0, marks_hi[63:48] - 16'd1, 3'd0);
    send(mrema_pkg::MODE_INTERP, 16'h0, 16'h0, marks_hi[63:48], 3'd0);
    send(mrema_pkg::MODE_INTERP, 16'h0, 16'h0, 16'hFFFF, 3'd0);
    send(mrema_pkg::MODE_READ, 16'h0, 16'h0, 16'h0, 3'd3);
    send(mrema_pkg::MODE_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7);
    send(mrema_pkg::MODE_READ, 16'h0, 16'h0, 16'h0, 3'd7);

    for (int phase = 0; phase < 7; phase++) begin
      settle();
      case (phase)
        0: program_regs('0, '0, 1);
        1: program_regs(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 2);
        2: program_regs(rand64(), rand64(), 3);
        default: program_regs(rand64(), rand64(), 0);
      endcase
      calm = (phase == 6);
      for (int n = 0; n < 250; n++) begin
        if (phase == 3 && n == 40) long_hold <= 1'b1;
        random_item();
      end
    end

    settle();
    $display("items taken: %0d pushes, %0d interpolations, %0d reads, %0d unused mode",
             sent[mrema_pkg::MODE_PUSH], sent[mrema_pkg::MODE_INTERP],
             sent[mrema_pkg::MODE_READ], sent[mrema_pkg::MODE_NONE]);
    $display("register settings: eight, incl. zero, full and unordered marks");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
